@@ rtl/ssm_pkg.sv @@
// ----------------------------------------------------------------------------
// Split spring smoother package
// Shared widths, register indexes and lane result type.
// ----------------------------------------------------------------------------
`default_nettype none

package ssm_pkg;

    localparam int PosW   = 32;  // position and velocity width
    localparam int RateW  = 16;  // spring rate width
    localparam int AxisW  = 16;  // axis component width
    localparam int DtW    = 16;  // time step width
    localparam int CfgAW  = 3;   // configuration index width
    localparam int CfgDW  = 16;  // configuration data width
    localparam int NAxes  = 3;

    // Configuration register indexes.
    localparam logic [CfgAW-1:0] CFG_SPRING_RATE = 3'd0;
    localparam logic [CfgAW-1:0] CFG_SLOW_RATE   = 3'd1;
    localparam logic [CfgAW-1:0] CFG_AXIS_X      = 3'd2;
    localparam logic [CfgAW-1:0] CFG_AXIS_Y      = 3'd3;
    localparam logic [CfgAW-1:0] CFG_AXIS_Z      = 3'd4;

    // Request kinds carried in tuser.
    localparam logic REQ_TICK    = 1'b0;
    localparam logic REQ_SET_POS = 1'b1;

    // One spring lane's finished velocity.
    typedef struct packed {
        logic                   done;
        logic                   sat;
        logic signed [PosW-1:0] vel;
    } t_lane_res;

    // Merge stage result.
    typedef struct packed {
        logic                   done;
        logic                   sat;
        logic signed [PosW-1:0] pos_x;
        logic signed [PosW-1:0] pos_y;
        logic signed [PosW-1:0] pos_z;
    } t_merge_res;

endpackage

`default_nettype wire

@@ rtl/ssm_lane.sv @@
// ----------------------------------------------------------------------------
// Spring lane
// One velocity update: (v + k*k*dt*diff) / (1+k*dt)^2 with two bit-serial
// restoring divisions, truncated toward zero and saturated to 32 bits.
// ----------------------------------------------------------------------------
`default_nettype none

module ssm_lane (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_start,
    input  wire logic [ssm_pkg::RateW-1:0]      i_k,
    input  wire logic [ssm_pkg::DtW-1:0]        i_dt,
    input  wire logic signed [ssm_pkg::PosW-1:0] i_vel,
    input  wire logic signed [ssm_pkg::PosW:0]  i_diff,
    output ssm_pkg::t_lane_res                  o_res
);
    import ssm_pkg::*;

    localparam int SW   = 25;        // divisor width
    localparam int GW   = 24;        // gain width
    localparam int NW   = 59;        // numerator width
    localparam int MW   = 58;        // magnitude width
    localparam int QW   = MW + 16;   // dividend width
    localparam int CntW = $clog2(QW);
    localparam logic [CntW-1:0] LastCnt = CntW'(QW - 1);

    typedef enum logic [5:0] {
        L_IDLE = 6'b000001,
        L_SG   = 6'b000010,
        L_NUM  = 6'b000100,
        L_MAG  = 6'b001000,
        L_DIV  = 6'b010000,
        L_OUT  = 6'b100000
    } t_lstate;

    t_lstate                r_state;
    logic [31:0]            r_kdt;
    logic [SW-1:0]          r_s;
    logic [GW-1:0]          r_g;
    logic signed [NW-1:0]   r_n;
    logic                   r_neg;
    logic [QW-1:0]          r_quo;
    logic [SW-1:0]          r_rem;
    logic [CntW-1:0]        r_cnt;
    logic                   r_pass;

    logic [47:0]            w_kkdt;
    logic [SW:0]            w_t;
    logic [SW:0]            w_sub;
    logic                   w_ge;
    logic [QW-1:0]          n_quo;
    logic [MW-1:0]          w_mag2;
    logic                   w_sat;

    // One restoring division step.
    always_comb begin
        w_kkdt = 48'(i_k) * 48'(r_kdt);
        w_t    = {r_rem, r_quo[QW-1]};
        w_sub  = w_t - {1'b0, r_s};
        w_ge   = (w_t >= {1'b0, r_s});
        n_quo  = {r_quo[QW-2:0], w_ge};
        w_mag2 = r_quo[MW+7:8];
        w_sat  = r_neg ? (w_mag2 > MW'(64'h8000_0000))
                       : (w_mag2 > MW'(64'h7FFF_FFFF));
    end

    // Lane sequencer and datapath.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= L_IDLE;
        end else begin
            case (r_state)
                L_IDLE: begin
                    if (i_start) begin
                        r_state <= L_SG;
                    end
                end
                L_SG:  r_state <= L_NUM;
                L_NUM: r_state <= L_MAG;
                L_MAG: r_state <= L_DIV;
                L_DIV: begin
                    if (r_cnt == LastCnt && r_pass) begin
                        r_state <= L_OUT;
                    end
                end
                L_OUT:   r_state <= L_IDLE;
                default: r_state <= L_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            L_IDLE: begin
                r_kdt <= 32'(i_k) * 32'(i_dt);
            end
            L_SG: begin
                r_s <= SW'((33'h100_0000 + 33'(r_kdt)) >> 8);
                r_g <= w_kkdt[47:24];
            end
            L_NUM: begin
                r_n <= (NW'(i_vel) <<< 8) + $signed({{(NW-GW){1'b0}}, r_g}) * NW'(i_diff);
            end
            L_MAG: begin
                r_neg  <= r_n[NW-1];
                r_quo  <= {(r_n[NW-1] ? MW'(-r_n) : MW'(r_n)), 16'b0};
                r_rem  <= '0;
                r_cnt  <= '0;
                r_pass <= 1'b0;
            end
            L_DIV: begin
                if (r_cnt == LastCnt && !r_pass) begin
                    // First quotient becomes the second dividend.
                    r_quo  <= {n_quo[MW-1:0], 16'b0};
                    r_rem  <= '0;
                    r_cnt  <= '0;
                    r_pass <= 1'b1;
                end else begin
                    r_rem <= w_ge ? w_sub[SW-1:0] : w_t[SW-1:0];
                    r_cnt <= r_cnt + 1'b1;
                    r_quo <= n_quo;
                end
            end
            default: begin
            end
        endcase
    end

    // Sign, saturation and result.
    always_comb begin
        o_res.done = (r_state == L_OUT);
        o_res.sat  = w_sat;
        if (w_sat) begin
            o_res.vel = r_neg ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
        end else begin
            o_res.vel = r_neg ? -$signed(w_mag2[31:0]) : $signed(w_mag2[31:0]);
        end
    end

endmodule

`default_nettype wire

@@ rtl/ssm_merge.sv @@
// ----------------------------------------------------------------------------
// Velocity merge
// Projects both velocities on the slow axis, forms the combined velocity and
// advances the position by it times dt, saturating to 32 bits.
// ----------------------------------------------------------------------------
`default_nettype none

module ssm_merge (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_start,
    input  wire logic [ssm_pkg::DtW-1:0]         i_dt,
    input  wire logic signed [ssm_pkg::AxisW-1:0] i_axis [ssm_pkg::NAxes],
    input  wire logic signed [ssm_pkg::PosW-1:0] i_mv   [ssm_pkg::NAxes],
    input  wire logic signed [ssm_pkg::PosW-1:0] i_sv   [ssm_pkg::NAxes],
    input  wire logic signed [ssm_pkg::PosW-1:0] i_pos  [ssm_pkg::NAxes],
    output ssm_pkg::t_merge_res                  o_res
);
    import ssm_pkg::*;

    logic [4:0]          r_stg;
    logic signed [47:0]  r_pm [NAxes];
    logic signed [47:0]  r_ps [NAxes];
    logic signed [35:0]  r_dm;
    logic signed [35:0]  r_ds;
    logic signed [37:0]  r_prm [NAxes];
    logic signed [37:0]  r_prs [NAxes];
    logic signed [39:0]  r_comb [NAxes];
    logic signed [40:0]  r_move [NAxes];

    logic signed [49:0]  w_sm;
    logic signed [49:0]  w_ss;
    logic signed [51:0]  w_qm [NAxes];
    logic signed [51:0]  w_qs [NAxes];
    logic signed [56:0]  w_mul [NAxes];
    logic signed [41:0]  w_sum [NAxes];
    logic [NAxes-1:0]    w_hi;
    logic [NAxes-1:0]    w_lo;
    logic signed [PosW-1:0] w_np [NAxes];

    always_comb begin
        w_sm = 50'(r_pm[0]) + 50'(r_pm[1]) + 50'(r_pm[2]);
        w_ss = 50'(r_ps[0]) + 50'(r_ps[1]) + 50'(r_ps[2]);
        for (int i = 0; i < NAxes; i++) begin
            w_qm[i]  = 52'(r_dm) * 52'(i_axis[i]);
            w_qs[i]  = 52'(r_ds) * 52'(i_axis[i]);
            w_mul[i] = 57'(r_comb[i]) * $signed({41'b0, i_dt});
            w_sum[i] = 42'(i_pos[i]) + 42'(r_move[i]);
            w_hi[i]  = (w_sum[i] > 42'sh0_7FFF_FFFF);
            w_lo[i]  = (w_sum[i] < -42'sh0_8000_0000);
            w_np[i]  = w_hi[i] ? 32'sh7FFF_FFFF :
                       w_lo[i] ? 32'sh8000_0000 : w_sum[i][31:0];
        end
    end

    // Stage valid chain.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stg <= '0;
        end else begin
            r_stg <= {r_stg[3:0], i_start};
        end
    end

    // Products, dot products, projections, combined velocity and move.
    always_ff @(posedge i_clk) begin
        for (int i = 0; i < NAxes; i++) begin
            r_pm[i]   <= 48'(i_mv[i]) * 48'(i_axis[i]);
            r_ps[i]   <= 48'(i_sv[i]) * 48'(i_axis[i]);
            r_prm[i]  <= 38'(w_qm[i] >>> 14);
            r_prs[i]  <= 38'(w_qs[i] >>> 14);
            r_comb[i] <= 40'(i_mv[i]) - 40'(r_prm[i]) + 40'(r_prs[i]);
            r_move[i] <= 41'(w_mul[i] >>> 16);
        end
        r_dm <= 36'(w_sm >>> 14);
        r_ds <= 36'(w_ss >>> 14);
    end

    always_comb begin
        o_res.done  = r_stg[4];
        o_res.sat   = |(w_hi | w_lo);
        o_res.pos_x = w_np[0];
        o_res.pos_y = w_np[1];
        o_res.pos_z = w_np[2];
    end

endmodule

`default_nettype wire

@@ rtl/axis_split_spring_smoother_top.sv @@
// ----------------------------------------------------------------------------
// Axis-split spring smoother, top level
// Six spring lanes (main and slow per axis) update the velocities side by
// side; a merge stage projects them and advances the position.
//
//  Channel  Direction  tdata (low bit up)                          tuser
//  s_axis   in         dt_step, target_x/y/z, new_x/y/z (208 bits)  req_type
//  m_axis   out        out_x, out_y, out_z (96 bits)               saturated
//  cfg      in         write enable, index 0..4, 16-bit data       -
//
// A tick passes through the lanes, which run lane set-up and hand-over and two
// 74-step bit-serial divisions each, then through the merge stage, and its result
// is loaded into the output register. A set-position item goes straight to the
// final state. One item is worked on at a time; the next is accepted
// once the result sits in the output register. A stalled output holds the block
// in its final state. Reset is synchronous, restores the configuration and
// clears the sequencer, positions, velocities and output valid flag.
// ----------------------------------------------------------------------------
`default_nettype none

module axis_split_spring_smoother_top (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_s_axis_tvalid,
    output logic                             o_s_axis_tready,
    // dt_step, target_x, target_y, target_z, new_x, new_y, new_z
    input  wire logic [207:0]                i_s_axis_tdata,
    // req_type
    input  wire logic                        i_s_axis_tuser,
    output logic                             o_m_axis_tvalid,
    input  wire logic                        i_m_axis_tready,
    // out_x, out_y, out_z
    output logic [95:0]                      o_m_axis_tdata,
    // saturated
    output logic                             o_m_axis_tuser,
    input  wire logic                        i_cfg_we,
    input  wire logic [ssm_pkg::CfgAW-1:0]   i_cfg_addr,
    input  wire logic [ssm_pkg::CfgDW-1:0]   i_cfg_wdata
);
    import ssm_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE   = 5'b00001,
        S_SPRING = 5'b00010,
        S_MSTART = 5'b00100,
        S_MERGE  = 5'b01000,
        S_FIN    = 5'b10000
    } t_state;

    t_state                 r_state;
    logic [RateW-1:0]       r_rate;
    logic [RateW-1:0]       r_slow_rate;
    logic signed [AxisW-1:0] r_axis [NAxes];
    logic signed [PosW-1:0] r_pos [NAxes];
    logic signed [PosW-1:0] r_mv  [NAxes];
    logic signed [PosW-1:0] r_sv  [NAxes];
    logic signed [PosW-1:0] r_tgt [NAxes];
    logic [DtW-1:0]         r_dt;
    logic                   r_sat;
    logic                   r_lstart;
    logic                   r_out_valid;
    logic [95:0]            r_out_data;
    logic                   r_out_sat;

    logic                   w_in_xfer;
    logic signed [PosW:0]   w_diff [NAxes];
    t_lane_res              w_main [NAxes];
    t_lane_res              w_slow [NAxes];
    t_merge_res             w_merge;
    logic                   w_lanes_done;
    logic                   w_lanes_sat;

    assign w_in_xfer       = i_s_axis_tvalid && o_s_axis_tready;
    assign o_s_axis_tready = (r_state == S_IDLE);
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;
    assign o_m_axis_tuser  = r_out_sat;

    // Spring lanes, one main and one slow per axis.
    for (genvar g = 0; g < NAxes; g++) begin : g_axis
        assign w_diff[g] = (PosW+1)'(r_tgt[g]) - (PosW+1)'(r_pos[g]);

        ssm_lane u_main (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_start (r_lstart),
            .i_k     (r_rate),
            .i_dt    (r_dt),
            .i_vel   (r_mv[g]),
            .i_diff  (w_diff[g]),
            .o_res   (w_main[g])
        );

        ssm_lane u_slow (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_start (r_lstart),
            .i_k     (r_slow_rate),
            .i_dt    (r_dt),
            .i_vel   (r_sv[g]),
            .i_diff  (w_diff[g]),
            .o_res   (w_slow[g])
        );
    end

    always_comb begin
        w_lanes_done = 1'b1;
        w_lanes_sat  = 1'b0;
        for (int i = 0; i < NAxes; i++) begin
            w_lanes_done = w_lanes_done & w_main[i].done & w_slow[i].done;
            w_lanes_sat  = w_lanes_sat | w_main[i].sat | w_slow[i].sat;
        end
    end

    // Projection and position update.
    ssm_merge u_merge (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_state == S_MSTART),
        .i_dt    (r_dt),
        .i_axis  (r_axis),
        .i_mv    (r_mv),
        .i_sv    (r_sv),
        .i_pos   (r_pos),
        .o_res   (w_merge)
    );

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rate      <= RateW'(2560);
            r_slow_rate <= RateW'(512);
            r_axis[0]   <= '0;
            r_axis[1]   <= AxisW'(16384);
            r_axis[2]   <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                CFG_SPRING_RATE: r_rate      <= i_cfg_wdata;
                CFG_SLOW_RATE:   r_slow_rate <= i_cfg_wdata;
                CFG_AXIS_X:      r_axis[0]   <= i_cfg_wdata;
                CFG_AXIS_Y:      r_axis[1]   <= i_cfg_wdata;
                CFG_AXIS_Z:      r_axis[2]   <= i_cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    // Sequencer and state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_lstart    <= 1'b0;
            r_out_valid <= 1'b0;
            r_sat       <= 1'b0;
            for (int i = 0; i < NAxes; i++) begin
                r_pos[i] <= '0;
                r_mv[i]  <= '0;
                r_sv[i]  <= '0;
            end
        end else begin
            r_lstart <= w_in_xfer && (i_s_axis_tuser == REQ_TICK);
            // The output register fills from the final state and empties on a transfer.
            if (r_state == S_FIN && (!r_out_valid || i_m_axis_tready)) begin
                r_out_valid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (w_in_xfer) begin
                        r_sat <= 1'b0;
                        if (i_s_axis_tuser == REQ_SET_POS) begin
                            r_pos[0] <= i_s_axis_tdata[143:112];
                            r_pos[1] <= i_s_axis_tdata[175:144];
                            r_pos[2] <= i_s_axis_tdata[207:176];
                            r_state  <= S_FIN;
                        end else begin
                            r_dt     <= i_s_axis_tdata[15:0];
                            r_tgt[0] <= i_s_axis_tdata[47:16];
                            r_tgt[1] <= i_s_axis_tdata[79:48];
                            r_tgt[2] <= i_s_axis_tdata[111:80];
                            r_state  <= S_SPRING;
                        end
                    end
                end
                S_SPRING: begin
                    if (w_lanes_done && !r_lstart) begin
                        for (int i = 0; i < NAxes; i++) begin
                            r_mv[i] <= w_main[i].vel;
                            r_sv[i] <= w_slow[i].vel;
                        end
                        r_sat   <= w_lanes_sat;
                        r_state <= S_MSTART;
                    end
                end
                S_MSTART: r_state <= S_MERGE;
                S_MERGE: begin
                    if (w_merge.done) begin
                        r_pos[0] <= w_merge.pos_x;
                        r_pos[1] <= w_merge.pos_y;
                        r_pos[2] <= w_merge.pos_z;
                        r_sat    <= r_sat | w_merge.sat;
                        r_state  <= S_FIN;
                    end
                end
                S_FIN: begin
                    if (!r_out_valid || i_m_axis_tready) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // Output register payload.
    always_ff @(posedge i_clk) begin
        if (r_state == S_FIN && (!r_out_valid || i_m_axis_tready)) begin
            r_out_data <= {r_pos[2], r_pos[1], r_pos[0]};
            r_out_sat  <= r_sat;
        end
    end

endmodule

`default_nettype wire
